// ===== rtl/insc_pkg.sv =====
// ---------------------------------------------------------------------------
// insc_pkg
// Shared types and constants for the integer nearest-neighbor image scaler.
// ---------------------------------------------------------------------------
package insc_pkg;

  // Frame and factor limits
  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_SCALE = 8;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_SCALE) + 1;  // holds 1..MAX_SCALE
  localparam int PH_W   = $clog2(MAX_SCALE);      // holds 0..MAX_SCALE-1
  localparam int SIZE_W = 11;                     // configured size field
  localparam int RGB_W  = 24;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 2'd3;

  // Scale modes and input commands
  localparam logic MODE_DOWN = 1'b0;
  localparam logic MODE_UP   = 1'b1;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Job queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // One output job: a pixel emitted cnt times
  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [CNT_W-1:0] cnt;
    logic             eor;
    logic             eof;
  } job_t;

endpackage

// ===== rtl/insc_front.sv =====
// ---------------------------------------------------------------------------
// insc_front
// Accepts items, tracks the frame position, owns the line buffer and the
// configuration registers, and turns each item into at most one job.
// ---------------------------------------------------------------------------
module insc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [insc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [insc_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_command,
  input  logic [7:0]                        in_red_in,
  input  logic [7:0]                        in_green_in,
  input  logic [7:0]                        in_blue_in,
  output logic                              job_push,
  output insc_pkg::job_t                    job_data,
  input  logic                              job_full
);

  localparam int CW = insc_pkg::COL_W;
  localparam int RW = insc_pkg::ROW_W;
  localparam int SW = insc_pkg::SIZE_W;
  localparam int NW = insc_pkg::CNT_W;
  localparam int PW = insc_pkg::PH_W;
  localparam int XW = SW + 1;

  // Configuration registers
  logic          scale_mode_r;
  logic [3:0]    scale_factor_r;
  logic [SW-1:0] image_cols_r;
  logic [SW-1:0] image_rows_r;

  // Position state
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] col_ph_r, col_ph_nxt;
  logic [PW-1:0] row_ph_r, row_ph_nxt;
  logic [PW-1:0] rp_pass_r, rp_pass_nxt;
  logic [CW-1:0] rp_col_r, rp_col_nxt;
  logic          rp_pend_r, rp_pend_nxt;

  // Job stage
  logic           job_v_r, job_v_nxt;
  insc_pkg::job_t job_r, job_nxt;
  logic           job_mem_r, job_mem_nxt;

  // Line buffer
  logic [insc_pkg::RGB_W-1:0] lb_mem [insc_pkg::MAX_COLS];
  logic [insc_pkg::RGB_W-1:0] lb_q_r;
  logic                       lb_we, lb_re;

  logic          acc;
  logic [NW-1:0] f_eff;
  logic [SW-1:0] cols_eff, rows_eff;
  logic [23:0]   rgb_in;

  assign rgb_in = {in_red_in, in_green_in, in_blue_in};

  // Clamp the configuration into range
  always_comb begin
    if (scale_factor_r == 4'd0) begin
      f_eff = NW'(1);
    end else if (scale_factor_r > 4'(insc_pkg::MAX_SCALE)) begin
      f_eff = NW'(insc_pkg::MAX_SCALE);
    end else begin
      f_eff = NW'(scale_factor_r);
    end
    if (image_cols_r == '0) begin
      cols_eff = SW'(1);
    end else if (image_cols_r > SW'(insc_pkg::MAX_COLS)) begin
      cols_eff = SW'(insc_pkg::MAX_COLS);
    end else begin
      cols_eff = image_cols_r;
    end
    if (image_rows_r == '0) begin
      rows_eff = SW'(1);
    end else if (image_rows_r > SW'(insc_pkg::MAX_ROWS)) begin
      rows_eff = SW'(insc_pkg::MAX_ROWS);
    end else begin
      rows_eff = image_rows_r;
    end
  end

  // Stall input only when the job stage cannot drain
  assign in_full  = job_v_r & job_full;
  assign acc      = in_push & ~in_full;
  assign job_push = job_v_r;

  always_comb begin
    job_data = job_r;
    if (job_mem_r) begin
      job_data.rgb = lb_q_r;
    end
  end

  // Next row index with wrap at the frame end
  function automatic logic [RW-1:0] adv_row(input logic [RW-1:0] r, input logic [SW-1:0] n);
    logic [SW-1:0] r1;
    begin
      r1 = SW'(r) + SW'(1);
      adv_row = (r1 >= n) ? '0 : RW'(r1);
    end
  endfunction

  // Classify the item and update the position
  always_comb begin
    logic [XW-1:0] col_x, row_x, f_x, cols_x, rows_x;
    logic [SW-1:0] col1, rpc1;
    logic [NW-1:0] pass1;
    logic [RW-1:0] row_a;
    logic          col_wrap, eor, fin;

    col_nxt     = col_r;
    row_nxt     = row_r;
    col_ph_nxt  = col_ph_r;
    row_ph_nxt  = row_ph_r;
    rp_pass_nxt = rp_pass_r;
    rp_col_nxt  = rp_col_r;
    rp_pend_nxt = rp_pend_r;
    job_nxt     = job_r;
    job_mem_nxt = job_mem_r;
    job_v_nxt   = job_v_r & job_full;
    lb_we       = 1'b0;
    lb_re       = 1'b0;

    col_x    = XW'(col_r);
    row_x    = XW'(row_r);
    f_x      = XW'(f_eff);
    cols_x   = XW'(cols_eff);
    rows_x   = XW'(rows_eff);
    col1     = SW'(col_r) + SW'(1);
    rpc1     = SW'(rp_col_r) + SW'(1);
    pass1    = NW'(rp_pass_r) + NW'(1);
    col_wrap = (col1 >= cols_eff);
    row_a    = rp_pend_r ? adv_row(row_r, rows_eff) : row_r;
    eor      = 1'b0;
    fin      = 1'b0;

    if (acc) begin
      job_v_nxt = 1'b0;
      if (scale_mode_r == insc_pkg::MODE_DOWN) begin
        if (in_command == insc_pkg::CMD_PIXEL) begin
          // Keep a pixel on the sampling grid inside the full groups
          eor             = (col_x + (f_x << 1)) > cols_x;
          job_nxt.rgb     = rgb_in;
          job_nxt.cnt     = NW'(1);
          job_nxt.eor     = eor;
          job_nxt.eof     = eor && ((row_x + (f_x << 1)) > rows_x);
          job_mem_nxt     = 1'b0;
          job_v_nxt       = (col_ph_r == '0) && (row_ph_r == '0) &&
                            ((col_x + f_x) <= cols_x) && ((row_x + f_x) <= rows_x);
          // Advance column, row and their phases
          if (col_wrap) begin
            col_nxt    = '0;
            col_ph_nxt = '0;
            row_nxt    = adv_row(row_r, rows_eff);
            if (row_nxt == '0 || (NW'(row_ph_r) + NW'(1)) == f_eff) begin
              row_ph_nxt = '0;
            end else begin
              row_ph_nxt = row_ph_r + PW'(1);
            end
          end else begin
            col_nxt = col_r + CW'(1);
            if ((NW'(col_ph_r) + NW'(1)) == f_eff) begin
              col_ph_nxt = '0;
            end else begin
              col_ph_nxt = col_ph_r + PW'(1);
            end
          end
        end
      end else if (in_command == insc_pkg::CMD_TICK) begin
        // Replay one stored pixel of the previous row
        if (rp_pend_r) begin
          eor         = (rpc1 >= cols_eff);
          fin         = (pass1 >= f_eff);
          lb_re       = 1'b1;
          job_v_nxt   = 1'b1;
          job_mem_nxt = 1'b1;
          job_nxt.cnt = f_eff;
          job_nxt.eor = eor;
          job_nxt.eof = eor && fin && ((SW'(row_r) + SW'(1)) >= rows_eff);
          if (eor) begin
            rp_col_nxt = '0;
            if (fin) begin
              rp_pend_nxt = 1'b0;
              rp_pass_nxt = '0;
              row_nxt     = adv_row(row_r, rows_eff);
            end else begin
              rp_pass_nxt = rp_pass_r + PW'(1);
            end
          end else begin
            rp_col_nxt = rp_col_r + CW'(1);
          end
        end
      end else begin
        // Store and replicate a source pixel, dropping any unfinished replay
        lb_we       = 1'b1;
        job_v_nxt   = 1'b1;
        job_mem_nxt = 1'b0;
        job_nxt.rgb = rgb_in;
        job_nxt.cnt = f_eff;
        job_nxt.eor = col_wrap;
        job_nxt.eof = col_wrap && (f_eff == NW'(1)) && ((SW'(row_a) + SW'(1)) >= rows_eff);
        rp_pend_nxt = 1'b0;
        rp_pass_nxt = '0;
        rp_col_nxt  = '0;
        row_nxt     = row_a;
        if (col_wrap) begin
          col_nxt = '0;
          if (f_eff > NW'(1)) begin
            rp_pend_nxt = 1'b1;
            rp_pass_nxt = PW'(1);
          end else begin
            row_nxt = adv_row(row_a, rows_eff);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  // Configuration writes restart the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r   <= insc_pkg::MODE_DOWN;
      scale_factor_r <= 4'd1;
      image_cols_r   <= SW'(insc_pkg::MAX_COLS);
      image_rows_r   <= SW'(insc_pkg::MAX_ROWS);
      col_r          <= '0;
      row_r          <= '0;
      col_ph_r       <= '0;
      row_ph_r       <= '0;
      rp_pass_r      <= '0;
      rp_col_r       <= '0;
      rp_pend_r      <= 1'b0;
      job_v_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        insc_pkg::CFG_SCALE_MODE:   scale_mode_r   <= cfg_wdata[0];
        insc_pkg::CFG_SCALE_FACTOR: scale_factor_r <= cfg_wdata[3:0];
        insc_pkg::CFG_IMAGE_COLS:   image_cols_r   <= cfg_wdata;
        insc_pkg::CFG_IMAGE_ROWS:   image_rows_r   <= cfg_wdata;
        default: ;
      endcase
      col_r     <= '0;
      row_r     <= '0;
      col_ph_r  <= '0;
      row_ph_r  <= '0;
      rp_pass_r <= '0;
      rp_col_r  <= '0;
      rp_pend_r <= 1'b0;
      job_v_r   <= job_v_nxt;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      col_ph_r  <= col_ph_nxt;
      row_ph_r  <= row_ph_nxt;
      rp_pass_r <= rp_pass_nxt;
      rp_col_r  <= rp_col_nxt;
      rp_pend_r <= rp_pend_nxt;
      job_v_r   <= job_v_nxt;
    end
  end

  // Hold the job payload
  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    job_mem_r <= job_mem_nxt;
  end

  // Line buffer: write a source pixel, read a replay pixel
  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[col_r] <= rgb_in;
    end
    if (lb_re) begin
      lb_q_r <= lb_mem[rp_col_r];
    end
  end

endmodule

// ===== rtl/insc_jobq.sv =====
// ---------------------------------------------------------------------------
// insc_jobq
// Short first-in first-out queue of jobs between the front and back parts.
// ---------------------------------------------------------------------------
module insc_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  insc_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output insc_pkg::job_t rdata,
  output logic           empty
);

  localparam int PW = insc_pkg::QPTR_W;

  insc_pkg::job_t q_mem [insc_pkg::QDEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(insc_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = q_mem[rp_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/insc_back.sv =====
// ---------------------------------------------------------------------------
// insc_back
// Expands each job into its copies, one output pixel per cycle while the
// receiver pops, through an output register.
// ---------------------------------------------------------------------------
module insc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_empty,
  input  insc_pkg::job_t job_data,
  output logic           job_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_red_out,
  output logic [7:0]     out_green_out,
  output logic [7:0]     out_blue_out,
  output logic           out_end_of_row,
  output logic           out_end_of_frame,
  output logic           out_last
);

  localparam int NW = insc_pkg::CNT_W;
  localparam int PW = insc_pkg::PH_W;

  logic          out_v_r;
  logic [PW-1:0] k_r;
  logic [23:0]   rgb_r;
  logic          eor_r, eof_r, last_r;
  logic          adv, take, fin;

  assign adv     = ~out_v_r | out_pop;
  assign take    = adv & ~job_empty;
  assign fin     = (NW'(k_r) + NW'(1)) == job_data.cnt;
  assign job_pop = take & fin;

  assign out_empty        = ~out_v_r;
  assign out_red_out      = rgb_r[23:16];
  assign out_green_out    = rgb_r[15:8];
  assign out_blue_out     = rgb_r[7:0];
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;
  assign out_last         = last_r;

  // Count copies and hold the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      k_r     <= '0;
    end else if (adv) begin
      out_v_r <= ~job_empty;
      if (take) begin
        k_r <= fin ? '0 : k_r + PW'(1);
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (take) begin
      rgb_r  <= job_data.rgb;
      eor_r  <= fin & job_data.eor;
      eof_r  <= fin & job_data.eof;
      last_r <= fin;
    end
  end

endmodule

// ===== rtl/integer_nearest_image_scaler.sv =====
// ---------------------------------------------------------------------------
// integer_nearest_image_scaler
// Nearest-neighbor integer up/down scaler for a row-major RGB stream.
// ---------------------------------------------------------------------------
// Input channel: push a source pixel (command 0) or a replay tick
// (command 1) while in_full is low. Results leave through a queue-style
// port: a pixel is shown while out_empty is low and taken with out_pop.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
// and restart the frame; write only while the block is idle.
// An accepted item passes the front's job register and the job queue
// before the output register shows its first result. Downscale takes
// one item per cycle while in_full is low. Upscale emits factor copies
// of each source or replayed pixel via the one-pixel-per-cycle output
// register; a four-job queue between front and back absorbs short bursts.
// Reset: downscale by 1 over a 1024 x 1024 frame, position at the origin,
// no replay pending, queues empty. The line buffer is not cleared.
// When the receiver holds off, results wait in the output register and
// job queue, and in_full rises once the queue is full and a further job
// waits at its input.
// ---------------------------------------------------------------------------
module integer_nearest_image_scaler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [insc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [insc_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_command,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic                           out_end_of_row,
  output logic                           out_end_of_frame,
  output logic                           out_last
);

  logic           fq_push, fq_full;
  insc_pkg::job_t fq_data;
  logic           bq_pop, bq_empty;
  insc_pkg::job_t bq_data;

  // Front: classify items and track position
  insc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_command  (in_command),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .job_push    (fq_push),
    .job_data    (fq_data),
    .job_full    (fq_full)
  );

  // Queue between front and back
  insc_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (bq_pop),
    .rdata (bq_data),
    .empty (bq_empty)
  );

  // Back: expand jobs into output pixels
  insc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (bq_empty),
    .job_data         (bq_data),
    .job_pop          (bq_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .out_last         (out_last)
  );

endmodule

// ===== test/tb_integer_nearest_image_scaler.sv =====
// ---------------------------------------------------------------------------
// tb_integer_nearest_image_scaler
// Self-checking bench for the integer nearest-neighbor image scaler. A
// directed table covers reset values, saturated registers, frame wrap, empty
// output frames, replay ticks and replay passes cut short by a new pixel.
// Random frames then run in both modes under bursty input and a stalling
// receiver. Every result is checked field by field against a behavioral
// copy of the scaler kept inside the bench, or against typed table values.
// ---------------------------------------------------------------------------
module tb_integer_nearest_image_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 180;
  localparam int MAX_REPORTS   = 100;
  localparam int DIR_ROWS      = 38;

  localparam int IW = insc_pkg::CFG_IDX_W;
  localparam int DW = insc_pkg::CFG_DAT_W;
  localparam int CW = insc_pkg::RGB_W;
  localparam int SW = insc_pkg::SIZE_W;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
    logic       last;
  } pixel_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;
  typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_ECHO} check_t;

  // One directed step: a register write or an item with its checking style
  typedef struct packed {
    row_kind_t     kind;
    logic [IW-1:0] index;
    logic [DW-1:0] value;
    logic          cmd;
    logic [CW-1:0] rgb;
    check_t        check;
    logic          eor;
    logic          eof;
  } step_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_wdata;
  logic          in_push;
  logic          in_full;
  logic          in_command;
  logic [7:0]    in_red_in;
  logic [7:0]    in_green_in;
  logic [7:0]    in_blue_in;
  logic          out_empty;
  logic          out_pop;
  logic [7:0]    out_red_out;
  logic [7:0]    out_green_out;
  logic [7:0]    out_blue_out;
  logic          out_end_of_row;
  logic          out_end_of_frame;
  logic          out_last;

  // Scaler state as the bench sees it
  logic          cur_mode = insc_pkg::MODE_DOWN;
  logic [3:0]    cur_factor = 4'd1;
  logic [SW-1:0] cur_cols = SW'(insc_pkg::MAX_COLS);
  logic [SW-1:0] cur_rows = SW'(insc_pkg::MAX_ROWS);
  logic [CW-1:0] row_store [insc_pkg::MAX_COLS];
  int            src_col = 0;
  int            src_row = 0;
  int            rp_pass = 0;
  int            rp_col = 0;
  bit            rp_pending = 0;

  pixel_t        scaled_pixels [$];
  bit            muted = 0;
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  bit            hold_request = 0;

  integer_nearest_image_scaler DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Behavioral scaler
  // -------------------------------------------------------------------------
  function automatic int eff_factor();
    int fv;
    fv = int'(cur_factor);
    if (fv == 0) return 1;
    if (fv > insc_pkg::MAX_SCALE) return insc_pkg::MAX_SCALE;
    return fv;
  endfunction

  function automatic int eff_size(logic [SW-1:0] v, int limit);
    int sv;
    sv = int'(v);
    if (sv == 0) return 1;
    if (sv > limit) return limit;
    return sv;
  endfunction

  function automatic int wrap_row(int rows);
    return (src_row + 1 >= rows) ? 0 : src_row + 1;
  endfunction

  // Queue f copies of a pixel; flags go on the final copy only
  task automatic emit_copies(logic [CW-1:0] rgb, int f, bit eor, bit eof);
    pixel_t p;
    if (muted) return;
    for (int k = 0; k < f; k++) begin
      p.red   = rgb[23:16];
      p.green = rgb[15:8];
      p.blue  = rgb[7:0];
      p.last  = (k == f - 1);
      p.eor   = eor && p.last;
      p.eof   = eof && p.last;
      scaled_pixels.push_back(p);
    end
  endtask

  task automatic rescale_item(logic cmd, logic [CW-1:0] rgb, output bit ignored);
    int f, cols, rows, ocols, orows;
    bit eor, eof, fin;
    f = eff_factor();
    cols = eff_size(cur_cols, insc_pkg::MAX_COLS);
    rows = eff_size(cur_rows, insc_pkg::MAX_ROWS);
    ignored = 0;
    if (cur_mode == insc_pkg::MODE_DOWN) begin
      // Decimate: keep pixels on the factor grid inside the whole groups
      ocols = cols / f;
      orows = rows / f;
      if (cmd == insc_pkg::CMD_TICK) begin
        ignored = 1;
        return;
      end
      if (src_col % f == 0 && src_row % f == 0 && src_col / f < ocols &&
          src_row / f < orows) begin
        eor = (src_col / f + 1 == ocols);
        eof = eor && (src_row / f + 1 == orows);
        emit_copies(rgb, 1, eor, eof);
      end
      if (src_col + 1 >= cols) begin
        src_col = 0;
        src_row = wrap_row(rows);
      end else begin
        src_col++;
      end
    end else if (cmd == insc_pkg::CMD_TICK) begin
      // Replay one stored pixel of the finished row
      if (!rp_pending) begin
        ignored = 1;
        return;
      end
      eor = (rp_col + 1 >= cols);
      fin = (rp_pass + 1 >= f);
      eof = eor && fin && (src_row + 1 >= rows);
      emit_copies(row_store[rp_col], f, eor, eof);
      if (eor) begin
        rp_col = 0;
        if (fin) begin
          rp_pending = 0;
          rp_pass = 0;
          src_row = wrap_row(rows);
        end else begin
          rp_pass++;
        end
      end else begin
        rp_col++;
      end
    end else begin
      // New pixel drops whatever replay passes remain
      if (rp_pending) begin
        rp_pending = 0;
        rp_pass = 0;
        rp_col = 0;
        src_row = wrap_row(rows);
      end
      row_store[src_col] = rgb;
      eor = (src_col + 1 >= cols);
      eof = eor && (f == 1) && (src_row + 1 >= rows);
      emit_copies(rgb, f, eor, eof);
      if (eor) begin
        src_col = 0;
        if (f > 1) begin
          rp_pending = 1;
          rp_pass = 1;
          rp_col = 0;
        end else begin
          src_row = wrap_row(rows);
        end
      end else begin
        src_col++;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic pause_input(int cycles);
    @(negedge clk);
    in_push <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_item(logic cmd, logic [CW-1:0] rgb, check_t check,
                           logic eor, logic eof, output bit ignored);
    pixel_t p;
    @(negedge clk);
    in_push     <= 1'b1;
    in_command  <= cmd;
    in_red_in   <= rgb[23:16];
    in_green_in <= rgb[15:8];
    in_blue_in  <= rgb[7:0];
    do begin
      @(posedge clk);
    end while (in_full);
    // Advance the model; typed rows replace its results with their own
    muted = (check != CHECK_MODEL);
    rescale_item(cmd, rgb, ignored);
    muted = 0;
    if (check == CHECK_ECHO) begin
      p = {rgb, eor, eof, 1'b1};
      scaled_pixels.push_back(p);
    end
    // Pace the sender in bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_input($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Wait until every result is out and the block has gone quiet
  task automatic wait_idle();
    pause_input(1);
    while (scaled_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      insc_pkg::CFG_SCALE_MODE:   cur_mode = value[0];
      insc_pkg::CFG_SCALE_FACTOR: cur_factor = value[3:0];
      insc_pkg::CFG_IMAGE_COLS:   cur_cols = value;
      insc_pkg::CFG_IMAGE_ROWS:   cur_rows = value;
      default:                    ;
    endcase
    // Any write restarts the frame
    src_col = 0;
    src_row = 0;
    rp_pass = 0;
    rp_col = 0;
    rp_pending = 0;
  endtask

  function automatic step_t reg_step(logic [IW-1:0] idx, logic [DW-1:0] value);
    step_t s;
    s = '0;
    s.kind  = ROW_WRITE;
    s.index = idx;
    s.value = value;
    return s;
  endfunction

  function automatic step_t item_step(logic cmd, logic [CW-1:0] rgb, check_t check,
                                      logic eor, logic eof);
    step_t s;
    s = '0;
    s.kind  = ROW_ITEM;
    s.cmd   = cmd;
    s.rgb   = rgb;
    s.check = check;
    s.eor   = eor;
    s.eof   = eof;
    return s;
  endfunction

  function automatic logic [DW-1:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DW'(insc_pkg::MAX_COLS);
      2:       return DW'($urandom_range(insc_pkg::MAX_COLS + 1, (1 << DW) - 1));
      3:       return DW'($urandom_range(13, 300));
      default: return DW'($urandom_range(1, 12));
    endcase
  endfunction

  // Mostly well-formed frames: replay ticks follow each finished upscale row
  function automatic logic pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (cur_mode == insc_pkg::MODE_UP && rp_pending) begin
      return (roll < 96) ? insc_pkg::CMD_TICK : insc_pkg::CMD_PIXEL;
    end
    return (roll < 92) ? insc_pkg::CMD_PIXEL : insc_pkg::CMD_TICK;
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    step_t         dir_tab [DIR_ROWS];
    bit            ignored;
    int            phase, phase_len, n, counted;
    logic          mode;
    logic [DW-1:0] factor;
    bit            write_all;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_push     = 1'b0;
    in_command  = insc_pkg::CMD_PIXEL;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;

    // Reset values: downscale by one over a full-size frame
    dir_tab[0]  = item_step(insc_pkg::CMD_PIXEL, 24'h000000, CHECK_ECHO, 1'b0, 1'b0);
    dir_tab[1]  = item_step(insc_pkg::CMD_PIXEL, 24'hFFFFFF, CHECK_ECHO, 1'b0, 1'b0);
    dir_tab[2]  = item_step(insc_pkg::CMD_TICK,  24'h5AA53C, CHECK_NONE, 1'b0, 1'b0);
    // Zero sizes and factor act as one: a one-pixel frame that wraps
    dir_tab[3]  = reg_step(insc_pkg::CFG_IMAGE_COLS, 11'd0);
    dir_tab[4]  = reg_step(insc_pkg::CFG_IMAGE_ROWS, 11'd0);
    dir_tab[5]  = reg_step(insc_pkg::CFG_SCALE_FACTOR, 11'd0);
    dir_tab[6]  = item_step(insc_pkg::CMD_PIXEL, 24'h123456, CHECK_ECHO, 1'b1, 1'b1);
    dir_tab[7]  = item_step(insc_pkg::CMD_PIXEL, 24'hABCDEF, CHECK_ECHO, 1'b1, 1'b1);
    // Oversized factor saturates; then a factor wider than the frame
    dir_tab[8]  = reg_step(insc_pkg::CFG_SCALE_FACTOR, 11'd15);
    dir_tab[9]  = reg_step(insc_pkg::CFG_IMAGE_COLS, 11'd9);
    dir_tab[10] = reg_step(insc_pkg::CFG_IMAGE_ROWS, 11'd9);
    dir_tab[11] = item_step(insc_pkg::CMD_PIXEL, 24'h804020, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[12] = item_step(insc_pkg::CMD_PIXEL, 24'h7FBFDF, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[13] = reg_step(insc_pkg::CFG_IMAGE_COLS, 11'd3);
    dir_tab[14] = item_step(insc_pkg::CMD_PIXEL, 24'h0F0F0F, CHECK_MODEL, 1'b0, 1'b0);
    // Upscale by two: idle tick, replay, replay cut short, full replay
    dir_tab[15] = reg_step(insc_pkg::CFG_SCALE_MODE, DW'(insc_pkg::MODE_UP));
    dir_tab[16] = reg_step(insc_pkg::CFG_SCALE_FACTOR, 11'd2);
    dir_tab[17] = reg_step(insc_pkg::CFG_IMAGE_COLS, 11'd2);
    dir_tab[18] = reg_step(insc_pkg::CFG_IMAGE_ROWS, 11'd2047);
    dir_tab[19] = item_step(insc_pkg::CMD_TICK,  24'hF0F0F0, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[20] = item_step(insc_pkg::CMD_PIXEL, 24'h112233, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[21] = item_step(insc_pkg::CMD_PIXEL, 24'h445566, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[22] = item_step(insc_pkg::CMD_TICK,  24'h000000, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[23] = item_step(insc_pkg::CMD_PIXEL, 24'h778899, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[24] = item_step(insc_pkg::CMD_PIXEL, 24'hAABBCC, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[25] = item_step(insc_pkg::CMD_TICK,  24'hFFFFFF, CHECK_MODEL, 1'b0, 1'b0);
    dir_tab[26] = item_step(insc_pkg::CMD_TICK,  24'h000000, CHECK_MODEL, 1'b0, 1'b0);
    // Largest factor on a one-pixel frame: eight copies per item
    dir_tab[27] = reg_step(insc_pkg::CFG_SCALE_FACTOR, 11'd8);
    dir_tab[28] = reg_step(insc_pkg::CFG_IMAGE_COLS, 11'd1);
    dir_tab[29] = reg_step(insc_pkg::CFG_IMAGE_ROWS, 11'd1);
    dir_tab[30] = item_step(insc_pkg::CMD_PIXEL, 24'hC3A55A, CHECK_MODEL, 1'b0, 1'b0);
    for (int i = 31; i < DIR_ROWS; i++) begin
      dir_tab[i] = item_step(insc_pkg::CMD_TICK, CW'(i), CHECK_MODEL, 1'b0, 1'b0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_tab[i].index, dir_tab[i].value);
      end else begin
        send_item(dir_tab[i].cmd, dir_tab[i].rgb, dir_tab[i].check,
                  dir_tab[i].eor, dir_tab[i].eof, ignored);
      end
    end

    // Random frames; the second one runs upscale under a long receiver hold
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      wait_idle();
      mode = (phase == 1) ? insc_pkg::MODE_UP : 1'($urandom_range(0, 1));
      factor = ($urandom_range(0, 4) == 0) ? DW'($urandom_range(0, 15))
                                           : DW'($urandom_range(1, insc_pkg::MAX_SCALE));
      write_all = (phase <= 1) || ($urandom_range(0, 3) == 0);
      write_reg(insc_pkg::CFG_SCALE_MODE, DW'(mode));
      if (write_all || $urandom_range(0, 1)) write_reg(insc_pkg::CFG_SCALE_FACTOR, factor);
      if (write_all || $urandom_range(0, 1)) write_reg(insc_pkg::CFG_IMAGE_COLS, pick_size());
      if (write_all || $urandom_range(0, 1)) write_reg(insc_pkg::CFG_IMAGE_ROWS, pick_size());
      phase_len = (phase == 1) ? 30 : $urandom_range(10, 40);
      n = 0;
      while (n < phase_len) begin
        send_item(pick_command(), CW'($urandom()), CHECK_MODEL, 1'b0, 1'b0, ignored);
        if (!ignored) begin
          n++;
          counted++;
          if (phase == 1 && n == 3) hold_request = 1;
        end
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_integer_nearest_image_scaler passed");
    end else begin
      $display("tb_integer_nearest_image_scaler failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: stretches of differing pop patterns, plus one long hold
  // -------------------------------------------------------------------------
  initial begin
    int         stretch;
    logic [7:0] pop_mask;
    logic [2:0] beat;
    out_pop  = 1'b0;
    stretch  = 0;
    pop_mask = 8'hFF;
    beat     = '0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // Hold off while the sender keeps offering items
        hold_request = 0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(8, 64);
          case ($urandom_range(0, 2))
            0:       pop_mask = 8'hFF;
            default: pop_mask = 8'($urandom_range(1, 255));
          endcase
        end
        stretch--;
        out_pop <= pop_mask[beat];
        beat++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string field, int got, int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_red_out, out_green_out, out_blue_out,
             out_end_of_row, out_end_of_frame, out_last};
      if (scaled_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", int'(got), 0);
      end else begin
        want = scaled_pixels.pop_front();
        if (got.red   !== want.red)   report_mismatch("red_out", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green_out", got.green, want.green);
        if (got.blue  !== want.blue)  report_mismatch("blue_out", got.blue, want.blue);
        if (got.eor   !== want.eor)   report_mismatch("end_of_row", got.eor, want.eor);
        if (got.eof   !== want.eof)   report_mismatch("end_of_frame", got.eof, want.eof);
        if (got.last  !== want.last)  report_mismatch("last", got.last, want.last);
      end
    end
  end

  // Stop the run when neither side has moved an item for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_integer_nearest_image_scaler failed");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/insc_pkg.sv
rtl/insc_front.sv
rtl/insc_jobq.sv
rtl/insc_back.sv
rtl/integer_nearest_image_scaler.sv
test/tb_integer_nearest_image_scaler.sv
